>>> rtl/core/alc_pkg.sv
// Shared types, constants and helpers for the ambient light LED controller.
package alc_pkg;

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LEVEL_BITS = 7;
    localparam int COMPARE_BITS = 10;
    localparam int ELAPSED_BITS = 16;
    localparam int RAW_BITS = 12;

    localparam logic [RAW_BITS-1:0] RAW_FLOOR = 12'd500;
    localparam logic [RAW_BITS-1:0] RAW_CEIL = 12'd2500;
    localparam logic [RAW_BITS-1:0] LED_LOW = 12'd1000;
    localparam logic [RAW_BITS-1:0] LED_HIGH = 12'd2000;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 7'd100;
    localparam logic [COMPARE_BITS-1:0] COMPARE_MAX = 10'd1000;

    // Reciprocals scaled by 2^16 for exact division by 20 and by 10 over the clamped range.
    localparam int RECIP_SHIFT = 16;
    localparam logic [11:0] RECIP_DIV20 = 12'd3277;
    localparam logic [12:0] RECIP_DIV10 = 13'd6554;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_AUTO_MODE      = 3'd0,
        REG_MANUAL_LEVEL   = 3'd1,
        REG_MANUAL_EDITING = 3'd2,
        REG_CYCLE_MS       = 3'd3,
        REG_OFF_MS         = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic                    auto_mode;
        logic [LEVEL_BITS-1:0]   manual_level;
        logic                    manual_editing;
        logic [ELAPSED_BITS-1:0] cycle_ms;
        logic [ELAPSED_BITS-1:0] off_ms;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]   ambient;
        logic [LEVEL_BITS-1:0]   led;
        logic [COMPARE_BITS-1:0] compare;
    } sample_t;

    // Ten times a percentage, built from two shifts.
    function automatic logic [COMPARE_BITS-1:0] scale_compare(input logic [LEVEL_BITS-1:0] level);
        logic [COMPARE_BITS-1:0] wide;
        begin
            wide = COMPARE_BITS'(level);
            scale_compare = (wide << 3) + (wide << 1);
        end
    endfunction

endpackage

>>> rtl/core/alc_tick_if.sv
// Input channel carrying one tick or re-sample request per beat.
interface alc_tick_if #(
    parameter int SENSOR_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [SENSOR_BITS-1:0] sensor_value;

    modport source (output valid, output action, output sensor_value, input ready);
    modport sink (input valid, input action, input sensor_value, output ready);
endinterface

>>> rtl/core/alc_status_if.sv
// Output channel carrying one controller status result per beat.
interface alc_status_if;
    import alc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COMPARE_BITS-1:0] pwm_compare;
    logic [LEVEL_BITS-1:0]   ambient_percent;
    logic [LEVEL_BITS-1:0]   led_percent;
    logic                    new_sample;
    logic                    sampling;

    modport source (output valid, output pwm_compare, output ambient_percent,
                    output led_percent, output new_sample, output sampling, input ready);
    modport sink (input valid, input pwm_compare, input ambient_percent,
                  input led_percent, input new_sample, input sampling, output ready);
endinterface

>>> rtl/core/ambient_light_led_controller.sv
// Top level of the ambient light LED controller: state update and result register.
// The tick channel takes one beat per millisecond tick (action 0, with the current
// sensor reading) or per forced re-sample request (action 1). Every input beat gives
// exactly one status beat on the status channel: PWM compare, ambient and LED
// percentages, a fresh-measurement flag and the blanking phase.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while no beat is in flight, which the block does not enforce;
// register indexes follow alc_pkg::reg_index_t. A beat passes the input register,
// then the state update and mapping logic into the result register. Throughput is
// one beat per cycle while the receiver is ready; the state registers update once
// per beat as it leaves the input register. When the receiver stalls, the result
// register holds its beat, the input register keeps one more beat, and tick.ready
// falls only when both are full. Reset returns the configuration to auto mode with a
// 10000 ms cycle and a 100 ms blanking time, clears both pipeline stages and puts the
// LED in the lit phase with all levels at zero.
module ambient_light_led_controller
    import alc_pkg::*;
#(
    parameter int SENSOR_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    alc_tick_if.sink                  tick,
    alc_status_if.source              status,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg;
    sample_t sample;

    logic                   in_valid_reg;
    logic                   in_action_reg;
    logic [SENSOR_BITS-1:0] in_sensor_reg;

    logic                    phase_reg;
    logic                    phase_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg;
    logic [ELAPSED_BITS-1:0] elapsed_next;
    logic [ELAPSED_BITS-1:0] elapsed_inc;
    logic [COMPARE_BITS-1:0] compare_reg;
    logic [COMPARE_BITS-1:0] compare_next;
    logic [LEVEL_BITS-1:0]   ambient_reg;
    logic [LEVEL_BITS-1:0]   ambient_next;
    logic [LEVEL_BITS-1:0]   led_reg;
    logic [LEVEL_BITS-1:0]   led_next;
    logic [LEVEL_BITS-1:0]   manual_sat;
    logic                    fresh;

    logic out_valid_reg;
    logic out_fresh_reg;
    logic advance;
    logic fire;

    alc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    alc_sample #(
        .SENSOR_BITS (SENSOR_BITS)
    ) u_sample (
        .raw    (in_sensor_reg),
        .sample (sample)
    );

    assign advance = !out_valid_reg || status.ready;
    assign fire = in_valid_reg && advance;
    assign tick.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            in_action_reg <= tick.action;
            in_sensor_reg <= tick.sensor_value;
        end
    end

    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + ELAPSED_BITS'(1) : elapsed_reg;
    assign manual_sat = (cfg.manual_level > LEVEL_MAX) ? LEVEL_MAX : cfg.manual_level;

    always_comb
    begin
        phase_next = phase_reg;
        elapsed_next = elapsed_reg;
        compare_next = compare_reg;
        ambient_next = ambient_reg;
        led_next = led_reg;
        fresh = 1'b0;
        if (in_action_reg)
        begin
            phase_next = 1'b1;
            elapsed_next = '0;
            compare_next = '0;
            ambient_next = '0;
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (!cfg.auto_mode)
            begin
                if (!cfg.manual_editing)
                begin
                    led_next = manual_sat;
                    compare_next = scale_compare(manual_sat);
                end
            end
            else if (!phase_reg)
            begin
                if (elapsed_inc >= cfg.cycle_ms)
                begin
                    phase_next = 1'b1;
                    compare_next = '0;
                    elapsed_next = '0;
                end
            end
            else if (elapsed_inc >= cfg.off_ms)
            begin
                ambient_next = sample.ambient;
                led_next = sample.led;
                compare_next = sample.compare;
                phase_next = 1'b0;
                elapsed_next = '0;
                fresh = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            elapsed_reg <= '0;
            compare_reg <= '0;
            ambient_reg <= '0;
            led_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                elapsed_reg <= elapsed_next;
                compare_reg <= compare_next;
                ambient_reg <= ambient_next;
                led_reg <= led_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_fresh_reg <= fresh;
        end
    end

    // The state registers double as the result payload.
    assign status.valid = out_valid_reg;
    assign status.pwm_compare = compare_reg;
    assign status.ambient_percent = ambient_reg;
    assign status.led_percent = led_reg;
    assign status.new_sample = out_fresh_reg;
    assign status.sampling = phase_reg;

    a_fresh_leaves_blanking: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.new_sample |-> !status.sampling)
        else $error("fresh measurement reported while still blanked");

    a_fresh_compare_matches: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.new_sample |->
            status.pwm_compare == scale_compare(status.led_percent))
        else $error("compare value does not follow the measured LED level");

    a_compare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> status.pwm_compare <= COMPARE_MAX)
        else $error("compare value above full scale");

    a_resample_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_action_reg |=>
            phase_reg && elapsed_reg == '0 && ambient_reg == '0 && compare_reg == '0)
        else $error("re-sample request did not blank and clear state");

endmodule

>>> rtl/core/alc_cfg_regs.sv
// Configuration register file written through a plain write port.
module alc_cfg_regs
    import alc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_AUTO_MODE:      cfg_next.auto_mode = cfg_data[0];
                REG_MANUAL_LEVEL:   cfg_next.manual_level = cfg_data[LEVEL_BITS-1:0];
                REG_MANUAL_EDITING: cfg_next.manual_editing = cfg_data[0];
                REG_CYCLE_MS:       cfg_next.cycle_ms = cfg_data[ELAPSED_BITS-1:0];
                REG_OFF_MS:         cfg_next.off_ms = cfg_data[ELAPSED_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_mode <= 1'b1;
            cfg_reg.manual_level <= '0;
            cfg_reg.manual_editing <= 1'b0;
            cfg_reg.cycle_ms <= 16'd10000;
            cfg_reg.off_ms <= 16'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/alc_sample.sv
// Maps a raw sensor reading to ambient percentage, LED level and PWM compare.
module alc_sample
    import alc_pkg::*;
#(
    parameter int SENSOR_BITS = 12
) (
    input  logic [SENSOR_BITS-1:0] raw,
    output sample_t                sample
);

    logic [RAW_BITS-1:0] clamped;
    logic [10:0]         amb_diff;
    logic [9:0]          led_diff;
    logic [22:0]         amb_prod;
    logic [22:0]         led_prod;
    logic [LEVEL_BITS-1:0] led_level;

    always_comb
    begin
        if (raw < SENSOR_BITS'(RAW_FLOOR))
        begin
            clamped = RAW_FLOOR;
        end
        else if (raw > SENSOR_BITS'(RAW_CEIL))
        begin
            clamped = RAW_CEIL;
        end
        else
        begin
            clamped = raw[RAW_BITS-1:0];
        end
    end

    assign amb_diff = 11'(clamped - RAW_FLOOR);
    assign led_diff = 10'(clamped - LED_LOW);
    assign amb_prod = 23'(amb_diff) * 23'(RECIP_DIV20);
    assign led_prod = 23'(led_diff) * 23'(RECIP_DIV10);

    always_comb
    begin
        priority if (clamped < LED_LOW)
        begin
            led_level = '0;
        end
        else if (clamped < LED_HIGH)
        begin
            led_level = led_prod[RECIP_SHIFT +: LEVEL_BITS];
        end
        else
        begin
            led_level = LEVEL_MAX;
        end
    end

    assign sample.ambient = amb_prod[RECIP_SHIFT +: LEVEL_BITS];
    assign sample.led = led_level;
    assign sample.compare = scale_compare(led_level);

endmodule
